/* rtl/ira_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ira_pkg
// Shared types, codes and constants of the interval region assigner.
// ----------------------------------------------------------------------------
package ira_pkg;

   localparam int REGION_DEPTH_DEF = 1024;
   localparam int POINT_DEPTH_DEF  = 65536;

   localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
   localparam logic [15:0] CHUNK_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_MAP     = 2'd1,
      OP_READ    = 2'd2,
      OP_RESTART = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_UNMAPPED  = 3'd1,
      ST_ERROR     = 3'd2,
      ST_BAD_RANGE = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_CHUNK_SIZE = 2'd0,
      CSR_MIN_GROUP  = 2'd1,
      CSR_STRICT_MAP = 2'd2
   } csr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_MAP_CHECK,
      S_MAP_FETCH,
      S_MAP_TEST,
      S_MAP_CHUNK,
      S_MAP_GROUP,
      S_READ_KEY,
      S_READ_SIZE,
      S_READ_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;      // latch request fields
      logic load_region;  // evaluate and write a region
      logic restart;      // clear point state
      logic region_rd;    // issue region read at current pointer
      logic advance;      // step region pointer
      logic chunk_step;   // bump count and chunk
      logic group_write;  // record a mapped point
      logic unmap_write;  // record an unmapped point
      logic point_full;   // report full table
      logic key_rd;       // read point key and group
      logic size_rd;      // read group size
      logic read_done;    // report a read-back
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic pts_full;     // point table full
      logic have_region;  // current pointer within loaded regions
      logic past_end;     // point at or past end of region
      logic can_advance;  // another region follows
      logic idx_bad;      // read index out of range
   } stat_type;

endpackage
`default_nettype wire

/* rtl/ira_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ira_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ira_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

/* rtl/ira_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ira_ctrl
// Sequencer of the assigner: steps loads, point mapping and read-backs.
// ----------------------------------------------------------------------------
module ira_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [1:0]      operation,
   input  wire ira_pkg::stat_type stat,
   output ira_pkg::cmd_type     cmd,
   output logic                 busy
);
   import ira_pkg::*;

   state_type state_ff, state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (op_type'(operation))
                  OP_LOAD:    state_in = S_LOAD;
                  OP_MAP:     state_in = S_MAP_CHECK;
                  OP_READ:    state_in = S_READ_KEY;
                  OP_RESTART: begin
                     cmd.restart = 1'b1;
                  end
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD: begin
            cmd.load_region = 1'b1;
            state_in = S_IDLE;
         end
         S_MAP_CHECK: begin
            if (stat.pts_full) begin
               cmd.point_full = 1'b1;
               state_in = S_IDLE;
            end else if (!stat.have_region) begin
               cmd.unmap_write = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.region_rd = 1'b1;
               state_in = S_MAP_FETCH;
            end
         end
         S_MAP_FETCH: state_in = S_MAP_TEST;
         S_MAP_TEST: begin
            // walk forward while the point is past the region end
            if (stat.past_end && stat.can_advance) begin
               cmd.advance   = 1'b1;
               cmd.region_rd = 1'b1;
               state_in = S_MAP_FETCH;
            end else begin
               state_in = S_MAP_CHUNK;
            end
         end
         S_MAP_CHUNK: begin
            cmd.chunk_step = 1'b1;
            state_in = S_MAP_GROUP;
         end
         S_MAP_GROUP: begin
            cmd.group_write = 1'b1;
            state_in = S_IDLE;
         end
         S_READ_KEY: begin
            if (stat.idx_bad) begin
               cmd.read_done = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.key_rd = 1'b1;
               state_in = S_READ_SIZE;
            end
         end
         S_READ_SIZE: begin
            cmd.size_rd = 1'b1;
            state_in = S_READ_DONE;
         end
         S_READ_DONE: begin
            cmd.read_done = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/ira_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ira_datapath
// Region table, point tables, counters and result registers.
// ----------------------------------------------------------------------------
module ira_datapath #(
   parameter int REGION_DEPTH = ira_pkg::REGION_DEPTH_DEF,
   parameter int POINT_DEPTH  = ira_pkg::POINT_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ira_pkg::cmd_type  cmd,
   output ira_pkg::stat_type      stat,
   input  wire logic [7:0]        req_chrom,
   input  wire logic [30:0]       req_start_pos,
   input  wire logic [30:0]       req_end_pos,
   input  wire logic [14:0]       req_label_in,
   input  wire logic [15:0]       req_point_index,
   input  wire logic [15:0]       chunk_size,
   input  wire logic [15:0]       min_group,
   input  wire logic              strict_map,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_status,
   output logic [14:0]            rsp_label_out,
   output logic [15:0]            rsp_chunk_out,
   output logic                   rsp_mapped
);
   import ira_pkg::*;

   localparam int RAW = $clog2(REGION_DEPTH);
   localparam int PAW = $clog2(POINT_DEPTH);
   localparam int RA  = (RAW < 1) ? 1 : RAW;
   localparam int PA  = (PAW < 1) ? 1 : PAW;
   localparam int RCW = $clog2(REGION_DEPTH + 1);
   localparam int PCW = $clog2(POINT_DEPTH + 1);
   localparam int REGW = 8 + 31 + 31 + 15;

   // captured request
   logic [7:0]  chrom_ff;
   logic [30:0] pos_ff;
   logic [30:0] end_ff;
   logic [14:0] label_ff;
   logic [15:0] idx_ff;

   // counters
   logic [RCW-1:0] loaded_ff, loaded_in;
   logic [RA-1:0]  cur_ff, cur_in;
   logic [16:0]    count_ff, count_in;
   logic [15:0]    sub_ff, sub_in;     // count modulo chunk size
   logic [15:0]    chunk_ff, chunk_in; // count / chunk size, saturated
   logic [PCW-1:0] seen_ff, seen_in;
   logic [PCW-1:0] groups_ff, groups_in;
   logic [31:0]    last_key_ff, last_key_in;
   logic [16:0]    gsize_ff, gsize_in; // size of open group
   logic           hit_ff;

   // output registers
   logic           valid_ff;
   logic [2:0]     status_ff;
   logic [14:0]    label_out_ff;
   logic [15:0]    chunk_out_ff;
   logic           mapped_ff;

   // region memory
   logic            reg_we;
   logic [REGW-1:0] reg_rdata;
   logic [7:0]      r_chrom;
   logic [30:0]     r_start, r_end;
   logic [14:0]     r_label;
   logic [RA-1:0]   reg_raddr;

   assign reg_we = cmd.load_region && (loaded_ff < RCW'(REGION_DEPTH))
                   && !(end_ff < pos_ff);
   assign {r_chrom, r_start, r_end, r_label} = reg_rdata;
   assign reg_raddr = cmd.advance ? RA'(cur_ff + 1'b1) : cur_ff;

   ira_ram #(.WIDTH(REGW), .DEPTH(REGION_DEPTH)) u_region (
      .clock (clock),
      .we    (reg_we),
      .waddr (loaded_ff[RA-1:0]),
      .wdata ({chrom_ff, pos_ff, end_ff, label_ff}),
      .raddr (reg_raddr),
      .rdata (reg_rdata)
   );

   // point key and group memory
   logic [31:0]   key_wdata;
   logic [PCW-1:0] grp_wdata;
   logic [31:0]   key_rdata;
   logic [PCW-1:0] grp_rdata;
   logic          pt_we;
   logic [31:0]   new_key;
   logic          new_group;
   logic [PCW-1:0] grp_idx;

   assign new_key   = {1'b1, r_label, chunk_ff};
   assign new_group = (groups_ff == '0) || (new_key != last_key_ff);
   assign grp_idx   = new_group ? groups_ff : PCW'(groups_ff - 1'b1);
   assign pt_we     = cmd.group_write || cmd.unmap_write;
   // a point that missed its region is recorded as unmapped
   assign key_wdata = (cmd.group_write && hit_ff) ? new_key : 32'd0;
   assign grp_wdata = (cmd.group_write && hit_ff) ? grp_idx : '0;

   ira_ram #(.WIDTH(32 + PCW), .DEPTH(POINT_DEPTH)) u_point (
      .clock (clock),
      .we    (pt_we),
      .waddr (seen_ff[PA-1:0]),
      .wdata ({key_wdata, grp_wdata}),
      .raddr (PA'(idx_ff)),
      .rdata ({key_rdata, grp_rdata})
   );

   // group size memory
   logic [16:0] gs_new;
   logic [16:0] gs_rdata;

   assign gs_new = new_group ? 17'd1
                   : ((gsize_ff < COUNT_MAX) ? 17'(gsize_ff + 1'b1) : gsize_ff);

   ira_ram #(.WIDTH(17), .DEPTH(POINT_DEPTH)) u_gsize (
      .clock (clock),
      .we    (cmd.group_write && hit_ff),
      .waddr (grp_idx[PA-1:0]),
      .wdata (gs_new),
      .raddr (grp_rdata[PA-1:0]),
      .rdata (gs_rdata)
   );

   // point and region compare, (chrom, pos) joint keys
   logic [38:0] pt_key, lo_key, hi_key;
   logic        in_region;

   assign pt_key    = {chrom_ff, pos_ff};
   assign lo_key    = {r_chrom, r_start};
   assign hi_key    = {r_chrom, r_end};
   assign in_region = (pt_key >= lo_key) && (pt_key < hi_key);

   // status to controller
   always_comb begin
      stat.pts_full    = (seen_ff >= PCW'(POINT_DEPTH));
      stat.have_region = (loaded_ff != '0) && (RCW'(cur_ff) < loaded_ff);
      stat.past_end    = (pt_key >= hi_key);
      stat.can_advance = (RCW'(cur_ff) + 1'b1 < loaded_ff);
      stat.idx_bad     = (32'(idx_ff) >= 32'(seen_ff))
                         || (32'(idx_ff) >= 32'(POINT_DEPTH));
   end

   // capture request fields
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         chrom_ff <= req_chrom;
         pos_ff   <= req_start_pos;
         end_ff   <= req_end_pos;
         label_ff <= req_label_in;
         idx_ff   <= req_point_index;
      end
   end

   // advance counters
   always_comb begin
      loaded_in   = loaded_ff;
      cur_in      = cur_ff;
      count_in    = count_ff;
      sub_in      = sub_ff;
      chunk_in    = chunk_ff;
      seen_in     = seen_ff;
      groups_in   = groups_ff;
      last_key_in = last_key_ff;
      gsize_in    = gsize_ff;
      if (reg_we) begin
         loaded_in = RCW'(loaded_ff + 1'b1);
      end
      if (cmd.restart) begin
         cur_in = '0; count_in = '0; sub_in = '0; chunk_in = '0;
         seen_in = '0; groups_in = '0; last_key_in = '0;
      end
      if (cmd.advance) begin
         cur_in = RA'(cur_ff + 1'b1);
         count_in = '0; sub_in = '0; chunk_in = '0;
      end
      // chunk kept as a saturating quotient of the in-region count, sub as its wrapping remainder
      if (cmd.chunk_step && in_region && count_ff < COUNT_MAX) begin
         count_in = 17'(count_ff + 1'b1);
         if (chunk_size != '0) begin
            if (17'(sub_ff) + 1'b1 >= 17'(chunk_size)) begin
               sub_in = '0;
               if (chunk_ff != CHUNK_MAX) begin
                  chunk_in = chunk_ff + 1'b1;
               end
            end else begin
               sub_in = sub_ff + 1'b1;
            end
         end
      end
      if (cmd.unmap_write) begin
         seen_in = PCW'(seen_ff + 1'b1);
      end
      if (cmd.group_write) begin
         seen_in = PCW'(seen_ff + 1'b1);
         if (hit_ff) begin
            gsize_in = gs_new;
            if (new_group) begin
               groups_in   = PCW'(groups_ff + 1'b1);
               last_key_in = new_key;
            end
         end
      end
   end

   // hold counters
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff   <= '0;
         cur_ff      <= '0;
         count_ff    <= '0;
         sub_ff      <= '0;
         chunk_ff    <= '0;
         seen_ff     <= '0;
         groups_ff   <= '0;
         last_key_ff <= '0;
      end else begin
         loaded_ff   <= loaded_in;
         cur_ff      <= cur_in;
         count_ff    <= count_in;
         sub_ff      <= sub_in;
         chunk_ff    <= chunk_in;
         seen_ff     <= seen_in;
         groups_ff   <= groups_in;
         last_key_ff <= last_key_in;
      end
      gsize_ff <= gsize_in;
      if (cmd.chunk_step) begin
         hit_ff <= in_region;
      end
   end

   // read-back chunk adjustment
   logic [15:0] rd_chunk;
   always_comb begin
      rd_chunk = key_rdata[15:0];
      if ((gs_rdata < 17'(min_group)) && (rd_chunk != '0)) begin
         rd_chunk = rd_chunk - 1'b1;
      end
   end

   // form the result
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.load_region || cmd.restart || cmd.point_full
                     || cmd.unmap_write || cmd.group_write || cmd.read_done;
      end
      status_ff    <= ST_OK;
      label_out_ff <= '0;
      chunk_out_ff <= '0;
      mapped_ff    <= 1'b0;
      if (cmd.load_region) begin
         if (loaded_ff >= RCW'(REGION_DEPTH)) begin
            status_ff <= ST_FULL;
         end else if (end_ff < pos_ff) begin
            status_ff <= ST_BAD_RANGE;
         end
      end
      if (cmd.point_full) begin
         status_ff <= ST_FULL;
      end
      if (cmd.unmap_write || (cmd.group_write && !hit_ff)) begin
         status_ff <= strict_map ? ST_ERROR : ST_UNMAPPED;
      end
      if (cmd.group_write && hit_ff) begin
         label_out_ff <= r_label;
         chunk_out_ff <= chunk_ff;
         mapped_ff    <= 1'b1;
      end
      if (cmd.read_done) begin
         if (stat.idx_bad || !key_rdata[31]) begin
            status_ff <= ST_UNMAPPED;
         end else begin
            label_out_ff <= key_rdata[30:16];
            chunk_out_ff <= rd_chunk;
            mapped_ff    <= 1'b1;
         end
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_label_out = label_out_ff;
   assign rsp_chunk_out = chunk_out_ff;
   assign rsp_mapped    = mapped_ff;

endmodule
`default_nettype wire

/* rtl/interval_region_assigner.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// interval_region_assigner
// Merge-joins sorted points against a loaded table of half-open regions.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one response
// appears on the rsp_ ports for a single cycle with rsp_valid high and cannot
// be stalled. A restart answers from idle, a load from S_LOAD, a read-back
// from S_READ_DONE (S_READ_KEY if out of range) and a map from S_MAP_GROUP,
// passing S_MAP_FETCH and S_MAP_TEST again for every region stepped over, as
// each step is a registered read of the region memory; a full point table or
// no region left makes the map answer from S_MAP_CHECK.
// busy drops as the response shows, so the next request can be taken then.
// ----------------------------------------------------------------------------
module interval_region_assigner #(
   parameter int REGION_DEPTH = ira_pkg::REGION_DEPTH_DEF,
   parameter int POINT_DEPTH  = ira_pkg::POINT_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_chrom,
   input  wire logic [30:0] req_start_pos,
   input  wire logic [30:0] req_end_pos,
   input  wire logic [14:0] req_label_in,
   input  wire logic [15:0] req_point_index,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [14:0]      rsp_label_out,
   output logic [15:0]      rsp_chunk_out,
   output logic             rsp_mapped,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import ira_pkg::*;

   logic [15:0] chunk_size_ff;
   logic [15:0] min_group_ff;
   logic        strict_map_ff;
   cmd_type     cmd;
   stat_type    stat;
   logic        csr_wr;

   // register write
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff <= '0;
         min_group_ff  <= 16'd1;
         strict_map_ff <= 1'b1;
      end else if (csr_wr) begin
         case (csr_type'(paddr[3:2]))
            CSR_CHUNK_SIZE: chunk_size_ff <= pwdata[15:0];
            CSR_MIN_GROUP:  min_group_ff  <= pwdata[15:0];
            CSR_STRICT_MAP: strict_map_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // register read
   always_comb begin
      prdata = '0;
      case (csr_type'(paddr[3:2]))
         CSR_CHUNK_SIZE: prdata = {16'd0, chunk_size_ff};
         CSR_MIN_GROUP:  prdata = {16'd0, min_group_ff};
         CSR_STRICT_MAP: prdata = {31'd0, strict_map_ff};
         default:        prdata = '0;
      endcase
   end

   ira_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_operation),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy)
   );

   ira_datapath #(.REGION_DEPTH(REGION_DEPTH), .POINT_DEPTH(POINT_DEPTH)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_chrom       (req_chrom),
      .req_start_pos   (req_start_pos),
      .req_end_pos     (req_end_pos),
      .req_label_in    (req_label_in),
      .req_point_index (req_point_index),
      .chunk_size      (chunk_size_ff),
      .min_group       (min_group_ff),
      .strict_map      (strict_map_ff),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_label_out   (rsp_label_out),
      .rsp_chunk_out   (rsp_chunk_out),
      .rsp_mapped      (rsp_mapped)
   );

endmodule
`default_nettype wire

/* bench/ira_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ira_checker
// Watches the request, response and register ports of the interval region
// assigner. It keeps its own copy of the region table, the point records, the
// group counts and the registers. It works out the response of every accepted
// request and compares each response, field by field, with the oldest one
// still awaited.
// ----------------------------------------------------------------------------
module ira_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_chrom,
   input  wire logic [30:0] req_start_pos,
   input  wire logic [30:0] req_end_pos,
   input  wire logic [14:0] req_label_in,
   input  wire logic [15:0] req_point_index,
   input  wire logic        rsp_valid,
   input  wire logic [2:0]  rsp_status,
   input  wire logic [14:0] rsp_label_out,
   input  wire logic [15:0] rsp_chunk_out,
   input  wire logic        rsp_mapped,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   input  wire logic        pready,
   output int               fail_count,
   output int               pending
);
   import ira_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [14:0] label;
      logic [15:0] chunk;
      logic        mapped;
   } rsp_item_type;

   rsp_item_type awaited_results[$];

   // region table copy
   logic [7:0]  tbl_chrom [REGION_DEPTH_DEF];
   logic [30:0] tbl_start [REGION_DEPTH_DEF];
   logic [30:0] tbl_end   [REGION_DEPTH_DEF];
   logic [14:0] tbl_label [REGION_DEPTH_DEF];
   logic [10:0] tbl_count;

   // point and group records
   logic [31:0] pt_key   [POINT_DEPTH_DEF];
   logic [16:0] pt_group [POINT_DEPTH_DEF];
   logic [16:0] grp_size [POINT_DEPTH_DEF];
   logic [9:0]  region_ptr;
   logic [16:0] region_hits;
   logic [16:0] pts_recorded;
   logic [16:0] grp_count;
   logic [31:0] grp_last_key;

   // register copy
   logic [15:0] cfg_chunk_size;
   logic [15:0] cfg_min_group;
   logic        cfg_strict_map;

   int mismatches;

   // Drop recorded points and groups, rewind the region pointer.
   task automatic clear_points();
      region_ptr   = '0;
      region_hits  = '0;
      pts_recorded = '0;
      grp_count    = '0;
      grp_last_key = '0;
   endtask

   // Join one point against the region table and record it.
   task automatic assign_point(input logic [7:0] chrom, input logic [30:0] pos,
                               output rsp_item_type res);
      logic [38:0] pt;
      int          r;
      logic [16:0] quot;
      logic [15:0] chunk;
      logic [31:0] key;
      pt  = {chrom, pos};
      res = '0;
      res.status = ST_OK;
      if (pts_recorded >= POINT_DEPTH_DEF) begin
         res.status = ST_FULL;
         return;
      end
      if (tbl_count > 0 && {1'b0, region_ptr} < tbl_count) begin
         r = region_ptr;
         // advance past regions that end at or before the point
         while (pt >= {tbl_chrom[r], tbl_end[r]} && r + 1 < tbl_count) begin
            r++;
            region_hits = '0;
         end
         region_ptr = r[9:0];
         if (pt >= {tbl_chrom[r], tbl_start[r]} && pt < {tbl_chrom[r], tbl_end[r]}) begin
            if (region_hits < COUNT_MAX) region_hits++;
            chunk = '0;
            if (cfg_chunk_size != 0) begin
               quot  = region_hits / cfg_chunk_size;
               chunk = (quot > 17'hFFFF) ? CHUNK_MAX : quot[15:0];
            end
            key = {1'b1, tbl_label[r], chunk};
            // open a new group when the key differs from the last one
            if (grp_count == 0 || key != grp_last_key) begin
               grp_size[grp_count[15:0]] = '0;
               grp_count++;
               grp_last_key = key;
            end
            if (grp_size[grp_count[15:0] - 16'd1] < COUNT_MAX)
               grp_size[grp_count[15:0] - 16'd1]++;
            pt_key[pts_recorded[15:0]]   = key;
            pt_group[pts_recorded[15:0]] = grp_count - 17'd1;
            pts_recorded++;
            res.label  = tbl_label[r];
            res.chunk  = chunk;
            res.mapped = 1'b1;
            return;
         end
      end
      // unmappable point
      pt_key[pts_recorded[15:0]]   = '0;
      pt_group[pts_recorded[15:0]] = '0;
      pts_recorded++;
      res.status = cfg_strict_map ? ST_ERROR : ST_UNMAPPED;
   endtask

   // Work out the response of one request and update the state copy.
   task automatic compute_response(output rsp_item_type res);
      logic [31:0] key;
      logic [15:0] chunk;
      logic [16:0] g;
      res = '0;
      res.status = ST_OK;
      case (op_type'(req_operation))
         OP_LOAD: begin
            if (tbl_count >= REGION_DEPTH_DEF) begin
               res.status = ST_FULL;
            end else if (req_end_pos < req_start_pos) begin
               res.status = ST_BAD_RANGE;
            end else begin
               tbl_chrom[tbl_count[9:0]] = req_chrom;
               tbl_start[tbl_count[9:0]] = req_start_pos;
               tbl_end[tbl_count[9:0]]   = req_end_pos;
               tbl_label[tbl_count[9:0]] = req_label_in;
               tbl_count++;
            end
         end
         OP_MAP: begin
            assign_point(req_chrom, req_start_pos, res);
         end
         OP_READ: begin
            if ({1'b0, req_point_index} >= pts_recorded || !pt_key[req_point_index][31]) begin
               res.status = ST_UNMAPPED;
            end else begin
               key   = pt_key[req_point_index];
               chunk = key[15:0];
               g     = pt_group[req_point_index];
               // undersized group reports the previous chunk
               if (grp_size[g[15:0]] < {1'b0, cfg_min_group} && chunk > 0) chunk--;
               res.label  = key[30:16];
               res.chunk  = chunk;
               res.mapped = 1'b1;
            end
         end
         default: begin
            clear_points();
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         awaited_results.delete();
         tbl_count      = '0;
         clear_points();
         cfg_chunk_size = 16'd0;
         cfg_min_group  = 16'd1;
         cfg_strict_map = 1'b1;
         mismatches     = 0;
      end else begin
         // compare a response with the oldest awaited one
         if (rsp_valid) begin
            got.status = status_type'(rsp_status);
            got.label  = rsp_label_out;
            got.chunk  = rsp_chunk_out;
            got.mapped = rsp_mapped;
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: status %0d label %0h chunk %0h mapped %0b",
                           rsp_status, rsp_label_out, rsp_chunk_out, rsp_mapped);
            end else begin
               want = awaited_results.pop_front();
               if (got != want) begin
                  mismatches++;
                  // fields are status/label/chunk/mapped
                  if (mismatches <= 10)
                     $display("response mismatch: expected %0d/%0h/%0h/%0b got %0d/%0h/%0h/%0b",
                              want.status, want.label, want.chunk, want.mapped,
                              got.status, got.label, got.chunk, got.mapped);
               end
            end
         end
         // predict an accepted request
         if (start && !busy) begin
            compute_response(want);
            awaited_results.insert(awaited_results.size(), want);
         end
         // track register writes
         if (psel && penable && pwrite && pready) begin
            case (csr_type'(paddr[3:2]))
               CSR_CHUNK_SIZE: cfg_chunk_size = pwdata[15:0];
               CSR_MIN_GROUP:  cfg_min_group  = pwdata[15:0];
               CSR_STRICT_MAP: cfg_strict_map = pwdata[0];
               default: ;
            endcase
         end
      end
      pending    <= awaited_results.size();
      fail_count <= mismatches;
   end

endmodule
`default_nettype wire

/* bench/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the interval region assigner.
// Loads a sorted region table, streams sorted points with interleaved
// read-backs and noise under several register settings, then extends the
// table up to the top chromosome and maps across it. The checker predicts and
// compares.
// ----------------------------------------------------------------------------
module tb;
   import ira_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_operation;
   logic [7:0]  req_chrom;
   logic [30:0] req_start_pos;
   logic [30:0] req_end_pos;
   logic [14:0] req_label_in;
   logic [15:0] req_point_index;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [14:0] rsp_label_out;
   logic [15:0] rsp_chunk_out;
   logic        rsp_mapped;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count;
   int          pending;

   // stimulus-side view of the stored regions
   logic [7:0]  rgn_chrom [$];
   logic [30:0] rgn_start [$];
   logic [30:0] rgn_end   [$];
   int          n_regions;
   int          n_sent;
   int          pts_mapped;
   logic [38:0] last_point;
   int          stall_cycles;

   interval_region_assigner dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_chrom(req_chrom),
      .req_start_pos(req_start_pos), .req_end_pos(req_end_pos),
      .req_label_in(req_label_in), .req_point_index(req_point_index),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_label_out(rsp_label_out), .rsp_chunk_out(rsp_chunk_out),
      .rsp_mapped(rsp_mapped),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   ira_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_chrom(req_chrom),
      .req_start_pos(req_start_pos), .req_end_pos(req_end_pos),
      .req_label_in(req_label_in), .req_point_index(req_point_index),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_label_out(rsp_label_out), .rsp_chunk_out(rsp_chunk_out),
      .rsp_mapped(rsp_mapped),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .pending(pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Present one request, hold it until taken, then maybe idle.
   task automatic send_request(input op_type op, input logic [7:0] chrom,
                               input logic [30:0] spos, input logic [30:0] epos,
                               input logic [14:0] lab, input logic [15:0] idx);
      int idle_pct;
      req_operation   <= op;
      req_chrom       <= chrom;
      req_start_pos   <= spos;
      req_end_pos     <= epos;
      req_label_in    <= lab;
      req_point_index <= idx;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      n_sent++;
      idle_pct = (n_sent < 400) ? 35 : (n_sent < 800) ? 62 : 0;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Hold off until every awaited response has come and the block is idle.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input csr_type reg_sel, input logic [31:0] value);
      drain();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_bad_range();
      logic [30:0] s;
      s = 31'($urandom_range(1, 32'h7FFFFFFF));
      send_request(OP_LOAD, 8'($urandom), s, 31'($urandom_range(0, s - 1)),
                   15'($urandom), 16'($urandom));
   endtask

   // Append n sorted regions over chromosomes c_lo..c_hi.
   task automatic add_regions(input int n, input int c_lo, input int c_hi, input bit top_end);
      int          i;
      int          c;
      int          prev_c;
      int          len_pick;
      logic [31:0] cursor;
      logic [30:0] s;
      logic [30:0] e;
      logic [14:0] lab;
      prev_c = -1;
      cursor = 0;
      for (i = 0; i < n; i++) begin
         c = c_lo + (i * (c_hi - c_lo + 1)) / n;
         if (c != prev_c) cursor = (i == 0) ? 0 : $urandom_range(0, 1000);
         prev_c = c;
         s = 31'(cursor + (($urandom_range(3) == 0) ? 0 : $urandom_range(1, 5000)));
         len_pick = $urandom_range(9);
         e = 31'(s + ((len_pick == 0) ? 0 : (len_pick < 5) ? $urandom_range(1, 20) :
                      $urandom_range(21, 200000)));
         if (top_end && i == n - 1) e = 31'h7FFFFFFF;
         cursor = 32'(e);
         lab = (i == 0) ? 15'd0 : (i == 1) ? 15'h7FFF : 15'($urandom_range(0, 32767));
         send_request(OP_LOAD, 8'(c), s, e, lab, 16'($urandom));
         if (n_regions < REGION_DEPTH_DEF) begin
            rgn_chrom.insert(n_regions, 8'(c));
            rgn_start.insert(n_regions, s);
            rgn_end.insert(n_regions, e);
            n_regions++;
         end
         if ($urandom_range(15) == 0) load_bad_range();
      end
   endtask

   // Random request of any kind, order and range.
   task automatic send_noise();
      case ($urandom_range(3))
         0: load_bad_range();
         1: send_request(OP_MAP, 8'($urandom), 31'($urandom), 31'($urandom),
                         15'($urandom), 16'($urandom));
         2: send_request(OP_READ, 8'($urandom), 31'($urandom), 31'($urandom),
                         15'($urandom), 16'($urandom));
         default: begin
            send_request(OP_RESTART, 8'($urandom), 31'($urandom), 31'($urandom),
                         15'($urandom), 16'($urandom));
            last_point = '0;
            pts_mapped = 0;
         end
      endcase
   endtask

   // Map a point if it keeps the stream sorted, with read-backs and noise.
   task automatic map_at(input logic [7:0] chrom, input logic [30:0] pos);
      logic [15:0] idx;
      if ({chrom, pos} >= last_point) begin
         send_request(OP_MAP, chrom, pos, 31'($urandom), 15'($urandom), 16'($urandom));
         last_point = {chrom, pos};
         pts_mapped++;
      end
      if ($urandom_range(4) == 0) begin
         idx = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, pts_mapped + 1));
         send_request(OP_READ, 8'($urandom), 31'($urandom), 31'($urandom),
                      15'($urandom), idx);
      end
      if ($urandom_range(15) == 0) send_noise();
   endtask

   // Walk the region table with a sorted stream of points.
   task automatic stream_points(input int budget, input int skip_pct);
      int          r;
      int          k;
      int          j;
      int          stop;
      logic [31:0] pos;
      logic [31:0] stride;
      stop = n_sent + budget;
      for (r = 0; r < n_regions && n_sent < stop; r++) begin
         if ($urandom_range(99) < skip_pct) continue;
         if (rgn_start[r] > 0 && $urandom_range(3) == 0)
            map_at(rgn_chrom[r], 31'(rgn_start[r] - 1'b1));
         k = ($urandom_range(4) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
         pos    = 32'(rgn_start[r]);
         stride = 32'((rgn_end[r] - rgn_start[r]) / (k + 1));
         if (rgn_end[r] != rgn_start[r]) begin
            for (j = 0; j < k; j++) begin
               map_at(rgn_chrom[r], pos[30:0]);
               pos = pos + $urandom_range(0, stride);
               if (pos >= 32'(rgn_end[r])) pos = 32'(rgn_end[r]) - 32'd1;
            end
         end
         if ($urandom_range(3) == 0) map_at(rgn_chrom[r], rgn_end[r]);
      end
      // points past the last region
      if (rgn_chrom[n_regions - 1] != 8'hFF) begin
         map_at(8'($urandom_range(rgn_chrom[n_regions - 1] + 1, 255)), 31'($urandom));
         map_at(8'hFF, 31'h7FFFFFFF);
      end
   endtask

   task automatic begin_phase(input logic [15:0] csize, input logic [15:0] mgroup,
                              input logic aall);
      csr_write(CSR_CHUNK_SIZE, {16'($urandom), csize});
      csr_write(CSR_MIN_GROUP, {16'($urandom), mgroup});
      csr_write(CSR_STRICT_MAP, {31'($urandom), aall});
      send_request(OP_RESTART, 8'($urandom), 31'($urandom), 31'($urandom),
                   15'($urandom), 16'($urandom));
      last_point = '0;
      pts_mapped = 0;
   endtask

   initial begin
      reset           <= 1'b1;
      start           <= 1'b0;
      req_operation   <= OP_LOAD;
      req_chrom       <= '0;
      req_start_pos   <= '0;
      req_end_pos     <= '0;
      req_label_in    <= '0;
      req_point_index <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      n_regions        = 0;
      n_sent           = 0;
      pts_mapped       = 0;
      last_point       = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no regions yet: points are unmappable under both settings
      send_request(OP_MAP, 8'd0, 31'd0, 31'd0, 15'd0, 16'd0);
      send_request(OP_READ, 8'd0, 31'd0, 31'd0, 15'd0, 16'd0);
      send_request(OP_READ, 8'd0, 31'd0, 31'd0, 15'd0, 16'hFFFF);
      csr_write(CSR_STRICT_MAP, 32'd0);
      send_request(OP_MAP, 8'hFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 15'h7FFF, 16'hFFFF);
      send_request(OP_LOAD, 8'hFF, 31'h7FFFFFFF, 31'd0, 15'h7FFF, 16'd0);
      send_request(OP_LOAD, 8'd0, 31'd1, 31'd0, 15'd0, 16'd0);
      send_request(OP_RESTART, 8'd0, 31'd0, 31'd0, 15'd0, 16'd0);
      send_request(OP_READ, 8'd0, 31'd0, 31'd0, 15'd0, 16'd0);

      // sorted table on the lower chromosomes
      add_regions(30, 0, 127, 1'b0);

      // sweep the registers across their extremes
      begin_phase(16'd0, 16'd1, 1'b1);
      stream_points(120, 20);
      begin_phase(16'd1, 16'd2, 1'b0);
      stream_points(120, 20);
      begin_phase(16'd3, 16'd4, 1'b1);
      stream_points(120, 20);
      begin_phase(16'hFFFF, 16'hFFFF, 1'b0);
      stream_points(120, 20);
      begin_phase(16'd2, 16'd0, 1'b1);
      stream_points(120, 20);
      begin_phase(16'd0, 16'hFFFF, 1'b0);
      stream_points(120, 20);

      // extend the table up to the top chromosome and end
      add_regions(40, 128, 255, 1'b1);
      load_bad_range();

      // map across the whole table
      begin_phase(16'd2, 16'd3, 1'b1);
      stream_points(200, 20);

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
rtl/ira_pkg.sv
rtl/ira_ram.sv
rtl/ira_ctrl.sv
rtl/ira_datapath.sv
rtl/interval_region_assigner.sv
bench/ira_checker.sv
bench/tb.sv
